// ===== hw/rtl/fps_pkg.sv =====
// fps_pkg: shared types and constants of the fenwick prefix sum table
// field widths, command and status codes, sequencer states, unit control
// no dependencies; imported by the interfaces and every module
package fps_pkg;

  localparam int unsigned CMD_W    = 1;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned ADDEND_W = 32;
  localparam int unsigned RANGE_W  = 11;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned TOTAL_W  = 64;
  // one-based walk index; holds twice the largest size so the upward step cannot wrap
  localparam int unsigned WALK_W   = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_ADD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_QEND,
    S_QSTART,
    S_FIN
  } fps_state_t;

  typedef logic [TOTAL_W-1:0] fps_word_t;
  typedef logic [WALK_W-1:0]  fps_walk_t;

  // control of the shared arithmetic unit
  typedef struct packed {
    logic sub;  // subtract table data from the operand
    logic up;   // index steps upward by its lowest set bit
  } fps_unit_ctl_t;

endpackage

// ===== hw/rtl/fps_if.sv =====
// fps_req_if and fps_rsp_if: valid/ready channels of the prefix sum table
// request carries one command, response carries one result
// depends on fps_pkg
interface fps_req_if
  import fps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [POS_W-1:0]    position;
  logic [ADDEND_W-1:0] addend;
  logic [RANGE_W-1:0]  range_start;
  logic [RANGE_W-1:0]  range_end;

  modport source (output valid, cmd, position, addend, range_start, range_end,
                  input ready);
  modport sink   (input valid, cmd, position, addend, range_start, range_end,
                  output ready);
endinterface

interface fps_rsp_if
  import fps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] range_total;
  logic               status;

  modport source (output valid, range_total, status, input ready);
  modport sink   (input valid, range_total, status, output ready);
endinterface

// ===== hw/rtl/fenwick_prefix_sum_table.sv =====
// fenwick_prefix_sum_table: binary indexed tree of signed 64-bit partial sums
// top level: sequencer, size register, output register; uses fps_table, fps_unit
// depends on fps_pkg and fps_if
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd, position, addend, range_start, range_end
//   rsp      out  valid/ready    range_total, status
//   cfg      in   cfg_wen        cfg_wdata (size_in_use)
//
// an add walks the entries on its upward path; a query walks the set bits of
// range_end and then of range_start; an error skips the walk; one table
// entry is read per cycle on the single read port
// after reset a clearing pass zeroes the table, with req not ready
// a result waits in the output register; the next transaction is taken meanwhile,
// and stalls only at its end if the previous result has still not been taken
module fenwick_prefix_sum_table
  import fps_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  fps_req_if.sink           req,
  fps_rsp_if.source         rsp,
  input  logic              cfg_wen,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  fps_state_t        state, state_next;
  logic [SIZE_W-1:0] size_in_use;
  logic [SIZE_W-1:0] eff_size;
  logic [SIZE_W-1:0] n;
  logic [AW-1:0]     clr_idx;
  fps_walk_t         idx;
  fps_walk_t         idx_step;
  logic [RANGE_W-1:0] start;
  logic [ADDEND_W-1:0] addend;
  fps_word_t         acc;
  fps_word_t         unit_a;
  fps_word_t         unit_sum;
  fps_word_t         rdata;
  logic              is_query;
  logic              status;
  logic              pend;
  logic              pend_sub;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              issue;
  logic              tbl_wen;
  logic [AW-1:0]     tbl_waddr;
  fps_word_t         tbl_wdata;
  logic              item_bad;
  logic              accept;
  logic              rsp_load;
  logic              rsp_valid;
  fps_word_t         rsp_total;
  logic              rsp_status;
  fps_unit_ctl_t     unit_ctl;

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_wen) begin
      size_in_use <= cfg_wdata;
    end
  end

  // effective size, never beyond the table
  assign eff_size = (32'(size_in_use) < TABLE_DEPTH) ? size_in_use : SIZE_W'(TABLE_DEPTH);

  // bounds check of an arriving transaction
  always_comb begin
    if (req.cmd == CMD_ADD) begin
      item_bad = ({1'b0, req.position} >= eff_size);
    end else begin
      item_bad = (req.range_start > req.range_end) || (req.range_end > eff_size);
    end
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == AW'(TABLE_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (item_bad)                 state_next = S_FIN;
          else if (req.cmd == CMD_ADD)  state_next = S_ADD;
          else                          state_next = S_QEND;
        end
      end
      S_ADD: begin
        if (idx > {1'b0, n}) state_next = S_FIN;
      end
      S_QEND: begin
        if (idx == '0) state_next = S_QSTART;
      end
      S_QSTART: begin
        if (idx == '0) state_next = S_FIN;
      end
      S_FIN: begin
        if (!pend && (!rsp_valid || rsp.ready)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue        = 1'b0;
    rsp_load     = 1'b0;
    unit_ctl.up  = 1'b0;
    unit_ctl.sub = pend_sub;
    unique case (state)
      S_ADD: begin
        issue       = (idx <= {1'b0, n});
        unit_ctl.up = 1'b1;
      end
      S_QEND, S_QSTART: begin
        issue = (idx != '0);
      end
      S_FIN: begin
        rsp_load = !pend && (!rsp_valid || rsp.ready);
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == S_CLEAR) begin
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // pending table read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= issue;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      acc      <= '0;
      is_query <= (req.cmd == CMD_QUERY);
      status   <= item_bad ? STATUS_BAD : STATUS_OK;
      n        <= eff_size;
      addend   <= req.addend;
      start    <= req.range_start;
      idx      <= (req.cmd == CMD_ADD) ? (WALK_W'(req.position) + WALK_W'(1))
                                       : WALK_W'(req.range_end);
    end else begin
      if (issue) begin
        idx      <= idx_step;
        wr_addr  <= rd_addr;
        pend_sub <= (state == S_QSTART);
      end else if (state == S_QEND) begin
        idx <= WALK_W'(start);
      end
      if (pend && is_query) begin
        acc <= unit_sum;
      end
    end
  end

  // shared unit: accumulates a query or forms the new partial sum of an add
  assign unit_a = is_query ? acc : {{(TOTAL_W - ADDEND_W){addend[ADDEND_W-1]}}, addend};

  fps_unit u_unit (
    .ctl      (unit_ctl),
    .a        (unit_a),
    .b        (rdata),
    .idx      (idx),
    .sum      (unit_sum),
    .idx_next (idx_step)
  );

  // table ports
  assign rd_addr   = AW'(idx - WALK_W'(1));
  assign tbl_wen   = (state == S_CLEAR) || (pend && !is_query);
  assign tbl_waddr = (state == S_CLEAR) ? clr_idx : wr_addr;
  assign tbl_wdata = (state == S_CLEAR) ? '0 : unit_sum;

  fps_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .wen   (tbl_wen),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_total  <= acc;
      rsp_status <= status;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.range_total = rsp_total;
  assign rsp.status      = rsp_status;

  // checks
  a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !rsp.valid)
    else $error("response valid during clearing pass");

  a_bad_skips_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && item_bad) |=> (state == S_FIN))
    else $error("out of bounds transaction started a walk");

  a_write_only_add: assert property (@(posedge clk) disable iff (rst)
    tbl_wen |-> (state == S_CLEAR || state == S_ADD))
    else $error("table written outside clear or add walk");

  a_add_total_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && !is_query) |=> (rsp.range_total == '0))
    else $error("add transaction returned a non-zero total");

endmodule

// ===== hw/rtl/fps_table.sv =====
// fps_table: partial sum memory, one write port and one registered read port
// depends on fps_pkg
module fps_table
  import fps_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  fps_word_t     wdata,
  input  logic [AW-1:0] raddr,
  output fps_word_t     rdata
);

  fps_word_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fps_unit.sv =====
// fps_unit: shared 64-bit adder/subtractor and lowest-set-bit index stepper
// depends on fps_pkg
module fps_unit
  import fps_pkg::*;
(
  input  fps_unit_ctl_t ctl,
  input  fps_word_t     a,
  input  fps_word_t     b,
  input  fps_walk_t     idx,
  output fps_word_t     sum,
  output fps_walk_t     idx_next
);

  fps_walk_t low_bit;

  // wrapping add or subtract of the table word
  assign sum = ctl.sub ? (a - b) : (a + b);

  // step by the lowest set bit of the one-based index
  assign low_bit  = idx & (~idx + WALK_W'(1));
  assign idx_next = ctl.up ? (idx + low_bit) : (idx - low_bit);

endmodule
